/* design/mnt_pkg.sv */
// mnt_pkg: shared types, status-class constants and the data-byte count
// lookup for the midi note transposer
// no dependencies
package mnt_pkg;

    // upper nibble of a status byte
    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
    localparam logic [3:0] NIB_CTRL       = 4'hB;
    localparam logic [3:0] NIB_PROGRAM    = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
    localparam logic [3:0] NIB_PITCH_BEND = 4'hE;

    localparam logic [7:0] TRANSPOSE_RESET = 8'sd6;

    // completed note message handed from the parser to the transposer
    typedef struct packed {
        logic [6:0] velocity;
        logic [6:0] note;
        logic [7:0] status;
    } note_evt_t;

    // number of data bytes that follow a status byte
    function automatic logic [1:0] args_for(input logic [7:0] status);
        logic [1:0] n;
        case (status[7:4])
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CTRL: n = 2'd2;
            NIB_PROGRAM, NIB_CHAN_PRESS:                         n = 2'd1;
            NIB_PITCH_BEND:                                      n = 2'd2;
            default:                                             n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

/* design/midi_note_transposer.sv */
// midi_note_transposer: top level, running-status midi parser with note
// transposition; depends on mnt_pkg, mnt_parser, mnt_queue, mnt_transposer
//
// Takes one raw midi byte per word on the s_ channel and emits one result
// word on the m_ channel for each completed note-on (0x9n) or note-off
// (0x8n) message whose note, shifted by the signed transpose register, lies
// in 1..127. Running status is supported; any status byte, real-time bytes
// included, restarts the message. Pitch bend expects two data bytes. The
// block takes one byte every cycle while s_tready is high: the parser
// updates its state on each byte and pushes completed note messages into
// a short queue, and the transposer adds the offset and loads the output
// register. A result passes through the queue and then that register.
// s_tready only drops when the queue is full, which happens only while the
// m_ side stalls. The transpose register (reset 6) is written through
// cfg_valid / cfg_data; cfg_ready is always high, and writes are to be made
// only while the block is idle.
module midi_note_transposer
    import mnt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2   // note events buffered between the two halves
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] midi_byte
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_status, [14:8] out_note,
                                    // [21:15] out_velocity, [23:22] zero
    // transpose register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data    // signed semitone offset
);

    // parser -> queue
    logic      pe_valid;
    logic      pe_ready;
    note_evt_t pe_evt;

    // queue -> transposer
    logic      qe_valid;
    logic      qe_ready;
    note_evt_t qe_evt;

    // result register
    note_evt_t res_evt;

    assign cfg_ready = 1'b1;

    // front: byte parser, one byte per cycle while the queue has room
    mnt_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .evt_valid (pe_valid),
        .evt_ready (pe_ready),
        .evt       (pe_evt)
    );

    // decoupling queue
    mnt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pe_valid),
        .in_ready  (pe_ready),
        .in_evt    (pe_evt),
        .out_valid (qe_valid),
        .out_ready (qe_ready),
        .out_evt   (qe_evt)
    );

    // back: transpose, range check, output register
    mnt_transposer u_transposer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .evt_valid (qe_valid),
        .evt_ready (qe_ready),
        .evt       (qe_evt),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_evt   (res_evt)
    );

    // pack the result word, status in the low byte
    assign m_tdata = {2'b00, res_evt.velocity, res_evt.note, res_evt.status};

endmodule

/* design/mnt_parser.sv */
// mnt_parser: front end, running-status byte parser that detects completed
// note-on / note-off messages and pushes them as events
// depends on mnt_pkg
module mnt_parser
    import mnt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       evt_valid,
    input  logic       evt_ready,
    output note_evt_t  evt
);

    logic [7:0]        rs_reg, rs_next;
    logic [6:0]        fd_reg, fd_next;
    logic signed [2:0] bl_reg, bl_next;
    logic [1:0]        wp_reg, wp_next;

    logic              accept;
    logic              reload;
    logic signed [2:0] bl_base;
    logic [1:0]        wp_base;
    logic              is_note;

    assign in_ready = evt_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        rs_next = rs_reg;
        fd_next = fd_reg;
        bl_next = bl_reg;
        wp_next = wp_reg;
        reload  = (wp_reg == 2'd0) || bl_reg[2] || (bl_reg == 3'sd0);
        bl_base = reload ? $signed({1'b0, args_for(rs_reg)}) : bl_reg;
        wp_base = reload ? 2'd1 : wp_reg;
        if (in_byte[7]) begin
            rs_next = in_byte;
            bl_next = $signed({1'b0, args_for(in_byte)});
            wp_next = 2'd1;
        end else begin
            if (wp_base == 2'd1) begin
                fd_next = in_byte[6:0];
            end
            wp_next = wp_base + 2'd1;
            bl_next = bl_base - 3'sd1;
        end
    end

    // only a data byte can close a message
    assign is_note      = (rs_reg[7:4] == NIB_NOTE_ON) || (rs_reg[7:4] == NIB_NOTE_OFF);
    assign evt_valid    = accept && !in_byte[7] && (bl_next == 3'sd0) && is_note;
    assign evt.status   = rs_reg;
    assign evt.note     = fd_next;
    assign evt.velocity = in_byte[6:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_reg <= '0;
            fd_reg <= '0;
            bl_reg <= '0;
            wp_reg <= '0;
        end else if (accept) begin
            rs_reg <= rs_next;
            fd_reg <= fd_next;
            bl_reg <= bl_next;
            wp_reg <= wp_next;
        end
    end

endmodule

/* design/mnt_queue.sv */
// mnt_queue: small show-ahead fifo of note events between parser and
// transposer
// depends on mnt_pkg
module mnt_queue
    import mnt_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  note_evt_t in_evt,
    output logic      out_valid,
    input  logic      out_ready,
    output note_evt_t out_evt
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    note_evt_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_evt   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_evt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/mnt_transposer.sv */
// mnt_transposer: back end, holds the transpose register, shifts the note,
// drops out-of-range notes and drives the registered result word
// depends on mnt_pkg
module mnt_transposer
    import mnt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic [7:0] cfg_data,
    input  logic       evt_valid,
    output logic       evt_ready,
    input  note_evt_t  evt,
    output logic       out_valid,
    input  logic       out_ready,
    output note_evt_t  out_evt
);

    logic [7:0] transpose_reg;
    logic       valid_reg, valid_next;
    note_evt_t  evt_reg;
    logic [8:0] sum;
    logic       in_range;
    logic       pop;

    // 9-bit sum covers -128..254
    assign sum       = {2'b00, evt.note} + {transpose_reg[7], transpose_reg};
    assign in_range  = !sum[8] && !sum[7] && (sum[6:0] != 7'd0);
    assign evt_ready = !valid_reg || out_ready;
    assign pop       = evt_valid && evt_ready;

    assign valid_next = (valid_reg && !out_ready) || (pop && in_range);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transpose_reg <= TRANSPOSE_RESET;
            valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                transpose_reg <= cfg_data;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && in_range) begin
            evt_reg.status   <= evt.status;
            evt_reg.note     <= sum[6:0];
            evt_reg.velocity <= evt.velocity;
        end
    end

    assign out_valid = valid_reg;
    assign out_evt   = evt_reg;

endmodule

/* design/mnt_checker.sv */
// mnt_checker: port-level assertions for midi_note_transposer, bound to
// the top level; depends only on the top level's ports
module mnt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result word stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // results only carry note-on or note-off status
    a_note_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:5] == 3'b100))
        else $error("result status is not a note message");

    // transposed note never lands on zero, padding stays clear
    a_note_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:8] != 7'd0) && (m_tdata[23:22] == 2'b00))
        else $error("result note out of range or padding set");

    // nothing comes out the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result word valid right after reset");

endmodule

bind midi_note_transposer mnt_checker u_mnt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb_top.sv */
// tb_top: self-checking testbench for midi_note_transposer, a running-status
// midi parser that transposes completed note messages
// depends on mnt_pkg and midi_note_transposer; a scoreboard class predicts results
module tb_top;
    import mnt_pkg::*;

    localparam logic [7:0] SYS_FIRST   = 8'hF0;   // lowest system status byte
    localparam logic [7:0] SYS_CLOCK   = 8'hF8;   // timing clock, a real-time byte
    localparam logic [7:0] SYS_LAST    = 8'hFF;   // system reset, a real-time byte
    localparam logic [7:0] DATA_MAX    = 8'h7F;
    localparam int CLK_HALF            = 6;
    localparam int RESET_CYCLES        = 6;
    localparam int SETTLE_CYCLES       = 6;
    localparam int DRAIN_CYCLES        = 8;
    localparam int STALL_LIMIT         = 1000;    // cycles with no word moving on any channel
    localparam int RANDOM_BYTES        = 1600;
    localparam int PHASES              = 10;

    // predicts the note words the block should emit and checks what it does emit
    class note_scoreboard;
        logic [7:0]        cur_status   = '0;
        logic [6:0]        first_byte   = '0;
        int                pending_data = 0;
        logic [1:0]        slot         = '0;
        logic signed [7:0] offset       = TRANSPOSE_RESET;
        note_evt_t         expected_q[$];
        int                errors        = 0;
        int                bytes_seen    = 0;
        int                notes_checked = 0;
        int                dropped       = 0;

        function int data_bytes_after(logic [7:0] status);
            case (status[7:4])
                NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CTRL, NIB_PITCH_BEND: return 2;
                NIB_PROGRAM, NIB_CHAN_PRESS: return 1;
                default: return 0;
            endcase
        endfunction

        function void set_transpose(logic [7:0] v);
            offset = v;
        endfunction

        function void note_input(logic [7:0] b);
            int        sum;
            note_evt_t evt;
            bytes_seen++;
            if (b[7]) begin
                cur_status   = b;
                pending_data = data_bytes_after(b);
                slot         = 2'd1;
            end else begin
                // no open message: fall back on running status
                if (slot == 2'd0 || pending_data <= 0) begin
                    pending_data = data_bytes_after(cur_status);
                    slot         = 2'd1;
                end
                if (slot == 2'd1)
                    first_byte = b[6:0];
                slot = slot + 2'd1;
                pending_data--;
            end
            if (pending_data == 0 &&
                (cur_status[7:4] == NIB_NOTE_ON || cur_status[7:4] == NIB_NOTE_OFF)) begin
                sum = int'(first_byte) + int'(offset);
                if (sum > 0 && sum < 128) begin
                    first_byte   = 7'(sum);
                    evt.status   = cur_status;
                    evt.note     = 7'(sum);
                    evt.velocity = b[6:0];
                    expected_q.push_back(evt);
                end else begin
                    dropped++;
                end
            end
        endfunction

        function void check_note(logic [23:0] word);
            note_evt_t got;
            note_evt_t want;
            got = word[21:0];
            if (expected_q.size() == 0) begin
                $error("result word %h with no note expected", word);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            notes_checked++;
            if (got.status != want.status) begin
                $error("out_status expected %h actual %h", want.status, got.status);
                errors++;
            end
            if (got.note != want.note) begin
                $error("out_note expected %0d actual %0d", want.note, got.note);
                errors++;
            end
            if (got.velocity != want.velocity) begin
                $error("out_velocity expected %0d actual %0d", want.velocity, got.velocity);
                errors++;
            end
            if (word[23:22] != 2'b00) begin
                $error("pad bits expected 0 actual %b", word[23:22]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] midi_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [7:0] out_status, [14:8] out_note, [21:15] out_velocity
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;    // signed transpose

    note_scoreboard sb;
    bit             quiet_tail = 1'b0;   // no idling on either side near the end
    int             gap_pct    = 0;      // chance of an input gap before a word
    bit             note_open  = 1'b0;   // last status sent was a note status
    int             stall_cycles = 0;
    int             settings_used = 0;

    midi_note_transposer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // result side: ready toggles in bursts, long ready stretches now and then
    initial begin : sink_pacing
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet_tail || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 9);
            end else begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 9);
            end
            repeat (n - 1) @(negedge aclk);
        end
    end

    // every accepted result word goes to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_note(m_tdata);
    end

    // watchdog on cycles where no word moves anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAIL midi_note_transposer");
            $finish;
        end
    end

    task automatic idle_input(input int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
        repeat (n - 1) @(negedge aclk);
    endtask

    // offer one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct)
            idle_input($urandom_range(1, 9));
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b);
        if (b[7])
            note_open = (b[7:4] == NIB_NOTE_ON || b[7:4] == NIB_NOTE_OFF);
    endtask

    // write the transpose register once the block has gone idle
    task automatic write_transpose(input logic [7:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_transpose(v);
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // note numbers at both ends under running status
    task automatic send_note_extremes();
        send_byte({NIB_NOTE_ON, 4'($urandom_range(0, 15))});
        send_byte(8'h00);
        send_byte(8'($urandom_range(0, 127)));
        send_byte(8'h01);
        send_byte(8'($urandom_range(0, 127)));
        send_byte(8'h7E);
        send_byte(8'($urandom_range(0, 127)));
        send_byte(DATA_MAX);
        send_byte(DATA_MAX);
    endtask

    // mostly well-formed note messages, some other channel traffic, system bytes and noise
    task automatic send_random_message();
        int         pick;
        int         count;
        logic [3:0] nib;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            if (!note_open || $urandom_range(0, 2) == 0) begin
                nib = $urandom_range(0, 1) ? NIB_NOTE_ON : NIB_NOTE_OFF;
                send_byte({nib, 4'($urandom_range(0, 15))});
            end
            send_byte(8'($urandom_range(0, 127)));
            // a real-time byte cutting the message breaks running status
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(SYS_CLOCK, SYS_LAST)));
            send_byte(8'($urandom_range(0, 127)));
        end else if (pick < 75) begin
            case ($urandom_range(0, 4))
                0:       nib = NIB_POLY_PRESS;
                1:       nib = NIB_CTRL;
                2:       nib = NIB_PROGRAM;
                3:       nib = NIB_CHAN_PRESS;
                default: nib = NIB_PITCH_BEND;
            endcase
            send_byte({nib, 4'($urandom_range(0, 15))});
            count = (nib == NIB_PROGRAM || nib == NIB_CHAN_PRESS) ? 1 : 2;
            repeat (count) send_byte(8'($urandom_range(0, 127)));
        end else if (pick < 85) begin
            send_byte(8'($urandom_range(SYS_FIRST, SYS_LAST)));
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 127)));
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [7:0] directed[$];
        int         plan[7];
        int         start_bytes;
        int         per_phase;
        logic [7:0] setting;

        sb        = new;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        plan      = '{127, -128, -127, 0, -5, 12, -1};
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed bytes under the reset transpose of +6
        directed = '{
            8'h00, DATA_MAX,                          // data before any status
            {NIB_NOTE_ON, 4'h0}, 8'h3C, DATA_MAX,     // plain note-on
            8'h00, 8'h00,                             // running status, note 0 velocity 0
            DATA_MAX, 8'h40,                          // transposed past 127, dropped
            {NIB_NOTE_OFF, 4'hF}, 8'h79, 8'h01,       // lands exactly on 127
            {NIB_NOTE_ON, 4'h5}, 8'h30, SYS_CLOCK, 8'h40, // real-time byte breaks the note
            {NIB_PITCH_BEND, 4'h2}, 8'h12, 8'h34,     // pitch bend takes two data bytes
            {NIB_PROGRAM, 4'h3}, 8'h05, 8'h06,        // one data byte, running status
            {NIB_CHAN_PRESS, 4'h1}, 8'h10,
            SYS_LAST, 8'h55                           // data after a system status
        };
        foreach (directed[i]) send_byte(directed[i]);

        per_phase   = RANDOM_BYTES / PHASES;
        start_bytes = sb.bytes_seen;
        for (int p = 0; p < PHASES; p++) begin
            setting = (p < 7) ? 8'(plan[p]) : 8'($urandom_range(0, 255));
            write_transpose(setting);
            quiet_tail = (p == PHASES - 1);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            send_note_extremes();
            while (sb.bytes_seen - start_bytes < per_phase * (p + 1))
                send_random_message();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d midi bytes over %0d transpose settings", sb.bytes_seen,
                 settings_used + 1);
        $display("%0d note words checked, %0d notes dropped as out of range",
                 sb.notes_checked, sb.dropped);
        if (sb.errors == 0)
            $display("PASS midi_note_transposer");
        else
            $display("FAIL midi_note_transposer");
        $finish;
    end

endmodule

/* midi_note_transposer.f */
design/mnt_pkg.sv
design/mnt_parser.sv
design/mnt_queue.sv
design/mnt_transposer.sv
design/midi_note_transposer.sv
design/mnt_checker.sv
tb/tb_top.sv
